[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/sdd_pkg.sv]
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared widths, request codes, segment table and divide constants.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int SHOWN          = 5;
  localparam int DIGITS_DEFAULT = 5;
  localparam int VALUE_W        = 17;
  localparam int KIND_W         = 2;
  localparam int COUNT_W        = 3;
  localparam int DIGIT_W        = 4;
  localparam int SEG_W          = 7;
  localparam int RECIP_W        = 18;

  localparam logic [SEG_W-1:0] BLANK_PATTERN = 7'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_AUTO  = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COUNT_W-1:0] digit_count;
    logic               point_thousands;
    logic               point_hundreds;
    logic               point_tens;
  } ctrl_t;

  typedef struct packed {
    logic [SHOWN-1:0][DIGIT_W-1:0] digit;
    logic [SHOWN-1:0]              reached;
  } bcd_t;

  typedef logic [RECIP_W-1:0] recip_t;

  // floor(v / 10^i) = (v * RECIP[i]) >> RECIP_SHIFT[i] for i >= 1, exact for any 17-bit v
  localparam recip_t RECIP [SHOWN] = '{
    18'd0, 18'd104858, 18'd167773, 18'd134218, 18'd107375
  };
  localparam int RECIP_SHIFT [SHOWN] = '{0, 20, 24, 27, 30};

  // Largest number that min(digits, SHOWN) decimal digits can hold
  function automatic logic [VALUE_W-1:0] clamp_limit(input int digits);
    int n;
    int lim;
    n   = (digits < SHOWN) ? digits : SHOWN;
    lim = 1;
    for (int i = 0; i < n; i++) begin
      lim = lim * 10;
    end
    return VALUE_W'(lim - 1);
  endfunction

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'h5F;
      4'd1:    p = 7'h50;
      4'd2:    p = 7'h6B;
      4'd3:    p = 7'h79;
      4'd4:    p = 7'h74;
      4'd5:    p = 7'h3D;
      4'd6:    p = 7'h3F;
      4'd7:    p = 7'h58;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h7D;
      default: p = BLANK_PATTERN;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/decimal_seven_segment_driver.sv]
// ----------------------------------------------------------------------------
// decimal_seven_segment_driver
// Binary value to five seven-segment digit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on kind, value, digit_count and the point flags and
//   raise start. The item is taken at the rising edge where start is high
//   and busy is low. busy is high only during reset and the cycle after it;
//   afterwards the block takes one item every cycle.
//   The value is clamped while it is captured in the input register; the
//   digit split (four parallel reciprocal multiplies), blanking and pattern
//   lookup sit between the input register and the result register.
//   done pulses for one cycle once the item has passed the input register
//   and the result register, with seg_ten_thousands .. seg_units valid in that cycle.
//   Throughput: one item per cycle, results in request order.
//   The receiver cannot stall: each result is shown exactly once.
//   Reset clears the valid pipeline; no result is produced from reset.
// ----------------------------------------------------------------------------
module decimal_seven_segment_driver #(
  parameter int DIGITS = sdd_pkg::DIGITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [sdd_pkg::KIND_W-1:0]  kind,
  input  logic [sdd_pkg::VALUE_W-1:0] value,
  input  logic [sdd_pkg::COUNT_W-1:0] digit_count,
  input  logic                        point_thousands,
  input  logic                        point_hundreds,
  input  logic                        point_tens,
  output logic                        done,
  output logic [sdd_pkg::SEG_W-1:0]   seg_ten_thousands,
  output logic [sdd_pkg::SEG_W-1:0]   seg_thousands,
  output logic [sdd_pkg::SEG_W-1:0]   seg_hundreds,
  output logic [sdd_pkg::SEG_W-1:0]   seg_tens,
  output logic [sdd_pkg::SEG_W-1:0]   seg_units
);
  import sdd_pkg::*;
  `include "assert_macros.svh"

  localparam logic [VALUE_W-1:0] LIMIT = clamp_limit(DIGITS);

  logic                          accept;
  logic                          in_valid;
  ctrl_t                         ctrl;
  ctrl_t                         ctrl_next;
  logic [VALUE_W-1:0]            value_q;
  logic [VALUE_W-1:0]            value_next;
  bcd_t                          bcd;
  logic [SHOWN-1:0][SEG_W-1:0]   seg_next;

  assign accept = start && !busy;

  always_comb begin
    ctrl_next.kind            = kind_t'(kind);
    ctrl_next.digit_count     = digit_count;
    ctrl_next.point_thousands = point_thousands;
    ctrl_next.point_hundreds  = point_hundreds;
    ctrl_next.point_tens      = point_tens;
    value_next = (value > LIMIT) ? LIMIT : value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl    <= ctrl_next;
      value_q <= value_next;
    end
    if (in_valid) begin
      seg_ten_thousands <= seg_next[4];
      seg_thousands     <= seg_next[3];
      seg_hundreds      <= seg_next[2];
      seg_tens          <= seg_next[1];
      seg_units         <= seg_next[0];
    end
  end

  sdd_bcd u_bcd (
    .value (value_q),
    .bcd   (bcd)
  );

  sdd_seg #(
    .DIGITS (DIGITS)
  ) u_seg (
    .ctrl (ctrl),
    .bcd  (bcd),
    .seg  (seg_next)
  );

  `ASSERT_NEXT(a_accept_loads, accept, in_valid)
  `ASSERT_NEXT(a_result_follows, in_valid, done)
  `ASSERT_SAME(a_done_has_source, done, $past(in_valid))
  `ASSERT_NEXT(a_clear_blanks,
    in_valid && ctrl.kind != KIND_AUTO && ctrl.kind != KIND_FIXED,
    seg_ten_thousands == BLANK_PATTERN && seg_thousands == BLANK_PATTERN &&
    seg_hundreds == BLANK_PATTERN && seg_tens == BLANK_PATTERN &&
    seg_units == BLANK_PATTERN)
  `ASSERT_NEXT(a_units_shown,
    in_valid && (ctrl.kind == KIND_AUTO || ctrl.kind == KIND_FIXED),
    seg_units != BLANK_PATTERN)

endmodule

[rtl/core/sdd_bcd.sv]
// ----------------------------------------------------------------------------
// sdd_bcd
// Binary to decimal digits by parallel reciprocal multiplies.
// ----------------------------------------------------------------------------
module sdd_bcd (
  input  logic [sdd_pkg::VALUE_W-1:0] value,
  output sdd_pkg::bcd_t               bcd
);
  import sdd_pkg::*;

  localparam int PROD_W = VALUE_W + RECIP_W;

  logic [SHOWN-1:0][VALUE_W-1:0] quot;
  logic [SHOWN-1:0][PROD_W-1:0]  prod;

  assign prod[0] = '0;
  assign quot[0] = value;

  // each quotient floor(value / 10^i) for i >= 1 comes from its own multiply
  for (genvar i = 1; i < SHOWN; i++) begin : g_quot
    assign prod[i] = PROD_W'(value) * PROD_W'(RECIP[i]);
    assign quot[i] = VALUE_W'(prod[i] >> RECIP_SHIFT[i]);
  end

  for (genvar i = 0; i < SHOWN; i++) begin : g_digit
    if (i < SHOWN - 1) begin : g_mid
      assign bcd.digit[i] = DIGIT_W'(quot[i] - VALUE_W'(quot[i+1] * VALUE_W'(10)));
    end else begin : g_top
      // value is clamped, so the top quotient is already one digit
      assign bcd.digit[i] = DIGIT_W'(quot[i]);
    end
    assign bcd.reached[i] = (quot[i] != '0);
  end

endmodule

[rtl/core/sdd_seg.sv]
// ----------------------------------------------------------------------------
// sdd_seg
// Per-digit blanking rules and segment lookup.
// ----------------------------------------------------------------------------
module sdd_seg #(
  parameter int DIGITS = sdd_pkg::DIGITS_DEFAULT
) (
  input  sdd_pkg::ctrl_t                                   ctrl,
  input  sdd_pkg::bcd_t                                    bcd,
  output logic [sdd_pkg::SHOWN-1:0][sdd_pkg::SEG_W-1:0]    seg
);
  import sdd_pkg::*;

  logic [SHOWN-1:0] show;
  logic [SHOWN-1:0] zero;

  always_comb begin
    for (int i = 0; i < SHOWN; i++) begin
      show[i] = 1'b0;
      zero[i] = 1'b0;
      case (ctrl.kind)
        KIND_AUTO: begin
          show[i] = (i == 0) || bcd.reached[i];
          // a lit point next to a blank digit turns it into a zero
          case (i)
            1:       zero[i] = ctrl.point_tens || ctrl.point_hundreds;
            2:       zero[i] = ctrl.point_hundreds;
            3:       zero[i] = ctrl.point_thousands;
            default: zero[i] = 1'b0;
          endcase
        end
        KIND_FIXED: begin
          show[i] = (i == 0) || (int'(ctrl.digit_count) > i);
        end
        default: begin
          show[i] = 1'b0;
        end
      endcase
      if (i >= DIGITS) begin
        show[i] = 1'b0;
        zero[i] = 1'b0;
      end
      if (show[i]) begin
        seg[i] = seg_pattern(bcd.digit[i]);
      end else if (zero[i]) begin
        seg[i] = seg_pattern('0);
      end else begin
        seg[i] = BLANK_PATTERN;
      end
    end
  end

endmodule

[verif/segment_pattern_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_pattern_checker
// Watches the request and result channels of the seven-segment driver,
// predicts the five digit patterns of every accepted request and compares
// each result against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module segment_pattern_checker
  import sdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [VALUE_W-1:0] value,
  input  logic [COUNT_W-1:0] digit_count,
  input  logic               point_thousands,
  input  logic               point_hundreds,
  input  logic               point_tens,
  input  logic               done,
  input  logic [SEG_W-1:0]   seg_ten_thousands,
  input  logic [SEG_W-1:0]   seg_thousands,
  input  logic [SEG_W-1:0]   seg_hundreds,
  input  logic [SEG_W-1:0]   seg_tens,
  input  logic [SEG_W-1:0]   seg_units,
  output int                 mismatch_count,
  output int                 patterns_owed
);

  localparam int unsigned LARGEST_SHOWN = 99999;

  typedef struct packed {
    logic [SEG_W-1:0] ten_thousands;
    logic [SEG_W-1:0] thousands;
    logic [SEG_W-1:0] hundreds;
    logic [SEG_W-1:0] tens;
    logic [SEG_W-1:0] units;
  } display_t;

  display_t pending_patterns[$];

  initial begin
    mismatch_count = 0;
    patterns_owed  = 0;
  end

  function automatic logic [SEG_W-1:0] digit_segments(input int unsigned d);
    logic [SEG_W-1:0] p;
    case (d)
      0:       p = 7'h5F;
      1:       p = 7'h50;
      2:       p = 7'h6B;
      3:       p = 7'h79;
      4:       p = 7'h74;
      5:       p = 7'h3D;
      6:       p = 7'h3F;
      7:       p = 7'h58;
      8:       p = 7'h7F;
      default: p = 7'h7D;
    endcase
    return p;
  endfunction

  function automatic display_t decode_display(input logic [KIND_W-1:0] req_kind,
                                              input logic [VALUE_W-1:0] raw,
                                              input logic [COUNT_W-1:0] count,
                                              input logic pt_th,
                                              input logic pt_hu,
                                              input logic pt_te);
    int unsigned      shown_value;
    int unsigned      rest;
    int unsigned      reach;
    int unsigned      d;
    logic             lit;
    logic             zero_fill;
    logic [SEG_W-1:0] pat [SHOWN];
    display_t         res;
    shown_value = (raw > LARGEST_SHOWN) ? LARGEST_SHOWN : raw;
    rest  = shown_value;
    reach = 1;
    for (int i = 0; i < SHOWN; i++) begin
      d = rest % 10;
      rest = rest / 10;
      zero_fill = 1'b0;
      case (req_kind)
        KIND_AUTO: begin
          lit = (i == 0) || (shown_value >= reach);
          // a lit point next to a blanked digit turns it into a zero
          case (i)
            1:       zero_fill = pt_te || pt_hu;
            2:       zero_fill = pt_hu;
            3:       zero_fill = pt_th;
            default: zero_fill = 1'b0;
          endcase
        end
        KIND_FIXED: lit = (i == 0) || (count > i);
        default:    lit = 1'b0;
      endcase
      if (lit)
        pat[i] = digit_segments(d);
      else if (zero_fill)
        pat[i] = digit_segments(0);
      else
        pat[i] = BLANK_PATTERN;
      reach = reach * 10;
    end
    res.ten_thousands = pat[4];
    res.thousands     = pat[3];
    res.hundreds      = pat[2];
    res.tens          = pat[1];
    res.units         = pat[0];
    return res;
  endfunction

  task automatic check_digit(input string label, input logic [SEG_W-1:0] want,
                             input logic [SEG_W-1:0] got, inout int bad);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, label, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    display_t want;
    int       bad;
    bad = 0;
    if (!rst) begin
      if (done) begin
        if (pending_patterns.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none actual %h %h %h %h %h",
                   $time, seg_ten_thousands, seg_thousands, seg_hundreds, seg_tens,
                   seg_units);
          bad++;
        end else begin
          want = pending_patterns.pop_front();
          check_digit("seg_ten_thousands", want.ten_thousands, seg_ten_thousands, bad);
          check_digit("seg_thousands", want.thousands, seg_thousands, bad);
          check_digit("seg_hundreds", want.hundreds, seg_hundreds, bad);
          check_digit("seg_tens", want.tens, seg_tens, bad);
          check_digit("seg_units", want.units, seg_units, bad);
        end
      end
      if (start && !busy)
        pending_patterns.push_back(decode_display(kind, value, digit_count,
                                                  point_thousands, point_hundreds,
                                                  point_tens));
    end
    mismatch_count <= mismatch_count + bad;
    patterns_owed  <= pending_patterns.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the decimal seven-segment driver. Sends directed corner
// requests and then random display requests, back to back or with random gaps;
// the checker predicts and compares every result, and this module gives the
// verdict once every outstanding result has come back.
// ----------------------------------------------------------------------------
module tb;
  import sdd_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [KIND_W-1:0]  kind = '0;
  logic [VALUE_W-1:0] value = '0;
  logic [COUNT_W-1:0] digit_count = '0;
  logic               point_thousands = 1'b0;
  logic               point_hundreds = 1'b0;
  logic               point_tens = 1'b0;
  logic               done;
  logic [SEG_W-1:0]   seg_ten_thousands;
  logic [SEG_W-1:0]   seg_thousands;
  logic [SEG_W-1:0]   seg_hundreds;
  logic [SEG_W-1:0]   seg_tens;
  logic [SEG_W-1:0]   seg_units;
  int                 mismatch_count;
  int                 patterns_owed;
  int                 cycle_count = 0;

  always #10 clk = ~clk;

  decimal_seven_segment_driver dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .kind              (kind),
    .value             (value),
    .digit_count       (digit_count),
    .point_thousands   (point_thousands),
    .point_hundreds    (point_hundreds),
    .point_tens        (point_tens),
    .done              (done),
    .seg_ten_thousands (seg_ten_thousands),
    .seg_thousands     (seg_thousands),
    .seg_hundreds      (seg_hundreds),
    .seg_tens          (seg_tens),
    .seg_units         (seg_units)
  );

  segment_pattern_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .kind              (kind),
    .value             (value),
    .digit_count       (digit_count),
    .point_thousands   (point_thousands),
    .point_hundreds    (point_hundreds),
    .point_tens        (point_tens),
    .done              (done),
    .seg_ten_thousands (seg_ten_thousands),
    .seg_thousands     (seg_thousands),
    .seg_hundreds      (seg_hundreds),
    .seg_tens          (seg_tens),
    .seg_units         (seg_units),
    .mismatch_count    (mismatch_count),
    .patterns_owed     (patterns_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold the item on the ports until it is taken; start stays high
  // straight into the next item when there is no gap.
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                              input logic [COUNT_W-1:0] cnt, input logic th,
                              input logic hu, input logic te, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    kind            <= k;
    value           <= v;
    digit_count     <= cnt;
    point_thousands <= th;
    point_hundreds  <= hu;
    point_tens      <= te;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int unsigned       sel;
    int unsigned       decade;
    logic [KIND_W-1:0] k;
    logic [VALUE_W-1:0] v;
    int                gap;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // leading blanking, points and clamping
    send_request(KIND_AUTO, 17'd0, 3'd0, 1'b0, 1'b0, 1'b0, 0);
    send_request(KIND_AUTO, 17'd0, 3'd7, 1'b1, 1'b1, 1'b1, 0);
    send_request(KIND_AUTO, 17'd5, 3'd0, 1'b0, 1'b0, 1'b1, 1);
    send_request(KIND_AUTO, 17'd7, 3'd0, 1'b0, 1'b1, 1'b0, 0);
    send_request(KIND_AUTO, 17'd42, 3'd0, 1'b1, 1'b0, 1'b0, 2);
    send_request(KIND_AUTO, 17'd9999, 3'd0, 1'b1, 1'b1, 1'b1, 0);
    send_request(KIND_AUTO, 17'd10000, 3'd0, 1'b0, 1'b0, 1'b0, 0);
    send_request(KIND_AUTO, 17'd99999, 3'd0, 1'b0, 1'b0, 1'b0, 3);
    send_request(KIND_AUTO, 17'd100000, 3'd0, 1'b0, 1'b0, 1'b0, 0);
    send_request(KIND_AUTO, 17'h1FFFF, 3'd0, 1'b1, 1'b1, 1'b1, 0);
    // every digit count, including the ones above five
    for (int c = 0; c < 8; c++)
      send_request(KIND_FIXED, 17'd12345 + 17'(c), 3'(c), c[0], c[1], c[2], c % 3);
    send_request(KIND_FIXED, 17'h1FFFF, 3'd5, 1'b0, 1'b0, 1'b0, 0);
    send_request(KIND_FIXED, 17'd0, 3'd7, 1'b1, 1'b1, 1'b1, 0);
    // clear and the unused code both blank everything
    send_request(KIND_CLEAR, 17'd12345, 3'd5, 1'b1, 1'b1, 1'b1, 0);
    send_request(KIND_CLEAR, 17'h1FFFF, 3'd7, 1'b0, 1'b0, 1'b0, 1);
    send_request(KIND_UNUSED, 17'd99999, 3'd5, 1'b1, 1'b1, 1'b1, 0);
    send_request(KIND_UNUSED, 17'd0, 3'd0, 1'b0, 1'b0, 1'b0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        k = KIND_AUTO;
      else if (sel < 8)
        k = KIND_FIXED;
      else if (sel < 9)
        k = KIND_CLEAR;
      else
        k = KIND_UNUSED;

      case ($urandom_range(0, 3))
        0: v = VALUE_W'($urandom_range(0, 131071));
        1: begin
          // land on either side of a power of ten
          decade = 1;
          repeat ($urandom_range(0, 5)) decade = decade * 10;
          v = VALUE_W'(decade + $urandom_range(0, 2) - 1);
          if (decade == 1)
            v = VALUE_W'($urandom_range(0, 2));
        end
        2: begin
          decade = 10;
          repeat ($urandom_range(0, 4)) decade = decade * 10;
          v = VALUE_W'($urandom_range(0, decade - 1));
        end
        default: v = VALUE_W'($urandom_range(99990, 131071));
      endcase

      // alternate back-to-back stretches with gapped ones
      gap = (((n / 150) % 2) == 0) ? 0 : $urandom_range(0, 12);
      send_request(k, v, COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
    end
    start <= 1'b0;

    @(posedge clk);
    while (patterns_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
